// ===== rtl/core/etq_pkg.sv =====
package etq_pkg;

  // Default sizes of the timer table and of the fire limit per check.
  localparam int unsigned SlotsDef    = 16;
  localparam int unsigned MaxFiresDef = 32;

  // Widest slot index the table may need (up to 1024 slots).
  localparam int unsigned IdxW = 10;

  // Request codes.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CHECK  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRE   = 2'd2;
  localparam logic [1:0] KIND_NEXT   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [47:0] DlMax = '1;

  // Operation applied to one cell of the chain.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_CLR,
    WR_FIRE
  } wr_op_e;

  // Search token that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic            go;
    logic            best_ok;
    logic [IdxW-1:0] best_idx;
    logic [47:0]     best_dl;
    logic [31:0]     best_id;
    logic            hit_ok;
    logic [IdxW-1:0] hit_idx;
    logic            free_ok;
    logic [IdxW-1:0] free_idx;
  } tok_t;

  // Update broadcast from the controller to the cells.
  typedef struct packed {
    wr_op_e          op;
    logic [IdxW-1:0] idx;
    logic [31:0]     id;
    logic [47:0]     dl;
    logic [30:0]     period;
    logic [16:0]     count;
  } wr_t;

  // Deadline plus period, saturating at the top of the 48-bit range.
  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [30:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {18'b0, b};
    return s[48] ? DlMax : s[47:0];
  endfunction

endpackage

// ===== rtl/core/etq_cell.sv =====
module etq_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   key_i,
  input  etq_pkg::tok_t tok_i,
  output etq_pkg::tok_t tok_o,
  input  etq_pkg::wr_t  wr_i
);
  import etq_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic        valid_q;
  logic [31:0] id_q;
  logic [47:0] dl_q;
  logic [30:0] period_q;
  logic [16:0] count_q;
  tok_t        tok_d, tok_q;
  logic        sel;

  // Fold this slot into the passing token.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.go) begin
      if (valid_q) begin
        if (!tok_i.best_ok || dl_q < tok_i.best_dl ||
            (dl_q == tok_i.best_dl && id_q < tok_i.best_id)) begin
          tok_d.best_ok  = 1'b1;
          tok_d.best_idx = MyIdx;
          tok_d.best_dl  = dl_q;
          tok_d.best_id  = id_q;
        end
        if (!tok_i.hit_ok && id_q == key_i) begin
          tok_d.hit_ok  = 1'b1;
          tok_d.hit_idx = MyIdx;
        end
      end else if (!tok_i.free_ok) begin
        tok_d.free_ok  = 1'b1;
        tok_d.free_idx = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign sel   = (wr_i.idx == MyIdx);

  // Slot valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      case (wr_i.op)
        WR_ADD:  valid_q <= 1'b1;
        WR_CLR:  valid_q <= 1'b0;
        WR_FIRE: if (count_q == 17'sd1) valid_q <= 1'b0;
        default: valid_q <= valid_q;
      endcase
    end
  end

  // Slot payload; a fired timer that stays armed is rescheduled.
  always_ff @(posedge clk_i) begin
    if (sel) begin
      case (wr_i.op)
        WR_ADD: begin
          id_q     <= wr_i.id;
          dl_q     <= wr_i.dl;
          period_q <= wr_i.period;
          count_q  <= wr_i.count;
        end
        WR_FIRE: begin
          if ($signed(count_q) > 17'sd1) count_q <= count_q - 17'd1;
          dl_q <= sat_add48(dl_q, period_q);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/expiring_timer_queue.sv =====
// Every request sweeps a search token through the row of SLOTS timer cells,
// one cell per cycle; the result is captured from the last cell and loaded
// into the output register once the output is free. A check spends a sweep
// per fired timer plus one closing sweep. One request is in flight at a time,
// so a new beat waits for the result; the chain and out_stall_i set the pace.
// Reset clears all slot valid bits, the id counter and the controller state.
module expiring_timer_queue #(
  parameter int unsigned SLOTS     = etq_pkg::SlotsDef,
  parameter int unsigned MAX_FIRES = etq_pkg::MaxFiresDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [47:0]        now_ms_i,
  input  logic signed [31:0] delay_ms_i,
  input  logic signed [16:0] repeat_count_i,
  input  logic [31:0]        target_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [1:0]         status_o,
  output logic [31:0]        fired_or_new_id_o,
  output logic signed [48:0] next_timeout_o,
  output logic               more_pending_o,
  output logic               last_o
);
  import etq_pkg::*;

  localparam int unsigned FW = $clog2(MAX_FIRES + 1);
  localparam logic [FW-1:0] FireLim = FW'(MAX_FIRES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DECIDE
  } st_e;

  st_e           state_q;
  logic [1:0]    mode_q;
  logic [47:0]   now_q;
  logic [30:0]   period_q;
  logic [16:0]   count_q;
  logic [31:0]   key_q;
  logic [31:0]   id_ctr_q;
  logic [FW-1:0] fires_q;
  logic          go_q;
  tok_t          res_q;
  tok_t          tok [SLOTS+1];
  tok_t          tok_in;
  wr_t           wr;
  logic          in_acc, out_free, expired;
  logic [48:0]   gap_ms;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign expired    = res_q.best_ok && (res_q.best_dl <= now_q);

  // Launch a fresh token into the first cell.
  always_comb begin
    tok_in    = '0;
    tok_in.go = go_q;
  end
  assign tok[0] = tok_in;

  // Row of timer cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    etq_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .wr_i   (wr)
    );
  end

  // Distance to the earliest deadline, or -1 with no timer armed.
  always_comb begin
    if (!res_q.best_ok) begin
      gap_ms = '1;
    end else if (res_q.best_dl < now_q) begin
      gap_ms = '0;
    end else begin
      gap_ms = {1'b0, res_q.best_dl - now_q};
    end
  end

  // Cell update chosen once the sweep result is in.
  always_comb begin
    wr        = '0;
    wr.op     = WR_NONE;
    wr.id     = key_q;
    wr.dl     = sat_add48(now_q, period_q);
    wr.period = period_q;
    wr.count  = count_q;
    if (state_q == S_DECIDE && out_free) begin
      unique case (mode_q)
        MODE_ADD: begin
          wr.idx = res_q.free_idx;
          if (!res_q.hit_ok && res_q.free_ok) wr.op = WR_ADD;
        end
        MODE_REMOVE: begin
          wr.idx = res_q.hit_idx;
          if (res_q.hit_ok) wr.op = WR_CLR;
        end
        MODE_CHECK: begin
          wr.idx = res_q.best_idx;
          if (expired && fires_q < FireLim) wr.op = WR_FIRE;
        end
        default: wr.idx = res_q.best_idx;
      endcase
    end
  end

  // Request sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      id_ctr_q          <= '0;
      fires_q           <= '0;
      go_q              <= 1'b0;
      out_valid_o       <= 1'b0;
      mode_q            <= MODE_QUERY;
      now_q             <= '0;
      period_q          <= '0;
      count_q           <= '0;
      key_q             <= '0;
      res_q             <= '0;
      kind_o            <= KIND_ADD;
      status_o          <= ST_OK;
      fired_or_new_id_o <= '0;
      next_timeout_o    <= '0;
      more_pending_o    <= 1'b0;
      last_o            <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mode_q   <= mode_i;
            now_q    <= now_ms_i;
            period_q <= delay_ms_i[31] ? 31'd0 : delay_ms_i[30:0];
            count_q  <= repeat_count_i;
            fires_q  <= '0;
            go_q     <= 1'b1;
            state_q  <= S_SWEEP;
            if (mode_i == MODE_ADD) begin
              id_ctr_q <= id_ctr_q + 32'd1;
              key_q    <= id_ctr_q + 32'd1;
            end else begin
              key_q <= target_id_i;
            end
          end
        end
        S_SWEEP: begin
          if (tok[SLOTS].go) begin
            res_q   <= tok[SLOTS];
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_valid_o       <= 1'b1;
            status_o          <= ST_OK;
            fired_or_new_id_o <= '0;
            next_timeout_o    <= '0;
            more_pending_o    <= 1'b0;
            last_o            <= 1'b1;
            state_q           <= S_IDLE;
            unique case (mode_q)
              MODE_ADD: begin
                kind_o <= KIND_ADD;
                if (res_q.hit_ok) begin
                  status_o <= ST_DUP;
                end else if (!res_q.free_ok) begin
                  status_o <= ST_FULL;
                end else begin
                  fired_or_new_id_o <= key_q;
                end
              end
              MODE_REMOVE: begin
                kind_o            <= KIND_REMOVE;
                fired_or_new_id_o <= key_q;
                if (!res_q.hit_ok) status_o <= ST_NOTFOUND;
              end
              MODE_CHECK: begin
                if (expired && fires_q < FireLim) begin
                  kind_o            <= KIND_FIRE;
                  fired_or_new_id_o <= res_q.best_id;
                  last_o            <= 1'b0;
                  fires_q           <= fires_q + FW'(1);
                  go_q              <= 1'b1;
                  state_q           <= S_SWEEP;
                end else begin
                  kind_o         <= KIND_NEXT;
                  next_timeout_o <= gap_ms;
                  more_pending_o <= expired;
                end
              end
              default: begin
                kind_o         <= KIND_NEXT;
                next_timeout_o <= gap_ms;
              end
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The fire count never passes the limit.
  a_fire_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fires_q <= FireLim) else $error("fire count over limit");

  // A token only leaves the chain while a sweep is awaited.
  a_tok_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[SLOTS].go |-> state_q == S_SWEEP) else $error("stray search token");

  // An accepted request blocks the input until it is done.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o) else $error("input open during request");

  // Cells are updated only while a result is being loaded.
  a_wr_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.op != WR_NONE |=> out_valid_o) else $error("update without result");
`endif

endmodule
